// ===== hdl/tfps_pkg.sv =====
// ============================================================================
// Tilt frame parser package
// Shared types and constants of the tilt frame parser and scaler.
// ============================================================================
package tfps_pkg;

    localparam logic [7:0]  HEADER_BYTE = 8'hAA;
    localparam logic [7:0]  FOOTER_BYTE = 8'h55;
    localparam logic [2:0]  LAST_POS    = 3'd7;
    localparam logic [3:0]  LEVEL_MAX   = 4'd10;
    localparam logic [3:0]  LEVEL_RESET = 4'd5;
    localparam logic [14:0] OUT_MAX     = 15'd32767;
    localparam logic [14:0] MID_VALUE   = 15'd16383;
    localparam logic [15:0] DEADZONE    = 16'd500;

    // One parsed frame as handed from the parser to the scaler.
    typedef struct packed {
        logic [15:0] pitch_raw;
        logic [15:0] roll_raw;
        logic        ok;
    } frame_t;

    // Queue status seen by the parser and the scaler.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Input limit for a sensitivity level; levels above ten read as ten.
    function automatic logic [14:0] limit_of(input logic [3:0] level);
        logic [14:0] lim;
        case (level)
            4'd0:    lim = 15'd18000;
            4'd1:    lim = 15'd16200;
            4'd2:    lim = 15'd14400;
            4'd3:    lim = 15'd12600;
            4'd4:    lim = 15'd10800;
            4'd5:    lim = 15'd9000;
            4'd6:    lim = 15'd7400;
            4'd7:    lim = 15'd5800;
            4'd8:    lim = 15'd4200;
            4'd9:    lim = 15'd2600;
            default: lim = 15'd1000;
        endcase
        return lim;
    endfunction

endpackage

// ===== hdl/tfps_front.sv =====
// ============================================================================
// Tilt frame parser front end
// Hunts for the header byte, collects the frame and checks the footer.
// ============================================================================
module tfps_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  tfps_pkg::qstat_t q_stat_i,
    output logic            push_o,
    output tfps_pkg::frame_t frame_o
);

    logic [2:0] pos_reg, pos_next;
    logic [7:0] pitch_hi_reg, pitch_lo_reg, roll_hi_reg, roll_lo_reg;
    logic       accept;

    // A word is only refused when the queue could not take a finished frame.
    assign s_tready = !q_stat_i.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (pos_reg == 3'd0 && s_tdata != tfps_pkg::HEADER_BYTE) begin
                pos_next = 3'd0;
            end else if (pos_reg == tfps_pkg::LAST_POS) begin
                pos_next = 3'd0;
            end else begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 3'd0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            case (pos_reg)
                3'd3:    pitch_hi_reg <= s_tdata;
                3'd4:    pitch_lo_reg <= s_tdata;
                3'd5:    roll_hi_reg  <= s_tdata;
                3'd6:    roll_lo_reg  <= s_tdata;
                default: ;
            endcase
        end
    end

    assign push_o            = accept && (pos_reg == tfps_pkg::LAST_POS);
    assign frame_o.pitch_raw = {pitch_hi_reg, pitch_lo_reg};
    assign frame_o.roll_raw  = {roll_hi_reg, roll_lo_reg};
    assign frame_o.ok        = (s_tdata == tfps_pkg::FOOTER_BYTE);

endmodule

// ===== hdl/tfps_queue.sv =====
// ============================================================================
// Tilt frame queue
// Short first-in first-out queue of parsed frames between parser and scaler.
// ============================================================================
module tfps_queue #(
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_i,
    input  tfps_pkg::frame_t data_i,
    input  logic             pop_i,
    output tfps_pkg::frame_t data_o,
    output tfps_pkg::qstat_t stat_o
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tfps_pkg::frame_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_i) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop_i) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push_i && !pop_i) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_i && !push_i) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem_reg[wr_ptr_reg] <= data_i;
        end
    end

    assign data_o       = mem_reg[rd_ptr_reg];
    assign stat_o.full  = (count_reg == CW'(DEPTH));
    assign stat_o.empty = (count_reg == '0);

endmodule

// ===== hdl/tfps_back.sv =====
// ============================================================================
// Tilt frame scaler back end
// Applies the deadzone, maps both angles with a two-lane serial divider and
// drives the output register.
// ============================================================================
module tfps_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [3:0]       level_i,
    input  tfps_pkg::qstat_t q_stat_i,
    input  tfps_pkg::frame_t q_data_i,
    output logic             pop_o,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,
    output logic             m_tuser
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0]  cnt_reg;
    logic        ok_reg;
    logic [14:0] lim_reg;
    logic [15:0] raw_reg [2];
    logic [15:0] n_reg [2];
    logic        lo_reg [2];
    logic        hi_reg [2];
    logic [15:0] rem_reg [2];
    logic [14:0] sh_reg [2];
    logic [14:0] q_reg [2];
    logic [14:0] held_reg [2];
    logic        m_tvalid_reg;
    logic [14:0] out_roll_reg, out_pitch_reg;
    logic        out_ok_reg;

    logic [15:0] divisor;
    logic [14:0] result [2];
    logic        out_load;

    assign divisor  = {lim_reg, 1'b0};
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign pop_o    = (state_reg == ST_IDLE) && !q_stat_i.empty;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            if (lo_reg[i]) begin
                result[i] = 15'd0;
            end else if (hi_reg[i]) begin
                result[i] = tfps_pkg::OUT_MAX;
            end else begin
                result[i] = q_reg[i];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_stat_i.empty) begin
                    state_next = q_data_i.ok ? ST_LOAD : ST_DONE;
                end
            end
            ST_LOAD: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == 4'd14) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            held_reg[0]  <= tfps_pkg::MID_VALUE;
            held_reg[1]  <= tfps_pkg::MID_VALUE;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (out_load && ok_reg) begin
                held_reg[0] <= result[0];
                held_reg[1] <= result[1];
            end
        end
    end

    // Lane 0 carries pitch, lane 1 carries roll.
    always_ff @(posedge aclk) begin
        logic [15:0] dz;
        logic [17:0] sum;
        logic [30:0] num;
        logic [16:0] trial;
        case (state_reg)
            ST_IDLE: begin
                ok_reg     <= q_data_i.ok;
                lim_reg    <= tfps_pkg::limit_of(level_i);
                raw_reg[0] <= q_data_i.pitch_raw;
                raw_reg[1] <= q_data_i.roll_raw;
            end
            ST_LOAD: begin
                for (int i = 0; i < 2; i++) begin
                    dz = raw_reg[i];
                    if ($signed(raw_reg[i]) > -$signed(tfps_pkg::DEADZONE)
                        && $signed(raw_reg[i]) < $signed(tfps_pkg::DEADZONE)) begin
                        dz = 16'd0;
                    end
                    sum       = {{2{dz[15]}}, dz} + {3'b000, lim_reg};
                    lo_reg[i] <= sum[17];
                    hi_reg[i] <= $signed(dz) >= $signed({1'b0, lim_reg});
                    n_reg[i]  <= sum[15:0];
                end
            end
            ST_MUL: begin
                cnt_reg <= 4'd0;
                for (int i = 0; i < 2; i++) begin
                    // n * 32767 as a shift and subtract.
                    num        = {n_reg[i], 15'd0} - {15'd0, n_reg[i]};
                    rem_reg[i] <= num[30:15];
                    sh_reg[i]  <= num[14:0];
                end
            end
            ST_DIV: begin
                cnt_reg <= cnt_reg + 4'd1;
                for (int i = 0; i < 2; i++) begin
                    trial = {rem_reg[i], sh_reg[i][14]};
                    if (trial >= {1'b0, divisor}) begin
                        rem_reg[i] <= 16'(trial - {1'b0, divisor});
                        q_reg[i]   <= {q_reg[i][13:0], 1'b1};
                    end else begin
                        rem_reg[i] <= trial[15:0];
                        q_reg[i]   <= {q_reg[i][13:0], 1'b0};
                    end
                    sh_reg[i] <= {sh_reg[i][13:0], 1'b0};
                end
            end
            default: ;
        endcase
        if (out_load) begin
            out_pitch_reg <= ok_reg ? result[0] : held_reg[0];
            out_roll_reg  <= ok_reg ? result[1] : held_reg[1];
            out_ok_reg    <= ok_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_pitch_reg, out_roll_reg};
    assign m_tuser  = out_ok_reg;

endmodule

// ===== hdl/tilt_frame_parser_scaler.sv =====
// ============================================================================
// Tilt frame parser and scaler
// Parses eight-byte tilt sensor frames and maps pitch and roll to 0..32767.
// ============================================================================
// Bytes arrive one word at a time on the s_ channel and are taken in one
// cycle each as long as the frame queue has room. Words are dropped until
// the header 0xAA shows up; that word and the next seven form a frame, with
// pitch in bytes 3..4 and roll in bytes 5..6 (signed, big endian) and the
// footer 0x55 in byte 7. Every finished frame gives exactly one word on the
// m_ channel: with a good footer both angles pass a +/-500 deadzone and are
// mapped as ((raw + L) * 32767) / (2 * L), saturated to 0..32767, and the
// held values follow; with a bad footer the held values (16383 after reset)
// come out unchanged and m_tuser is low. A good frame occupies the scaler
// while its 15-step serial divider works on both angles side by side; a
// rejected frame skips the divider. The parser keeps taking the next
// frame's bytes meanwhile, so the input stalls only when the frame queue is
// full. The sensitivity level selects L from a fixed table and saturates
// at ten on write.
// ============================================================================
module tilt_frame_parser_scaler #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: sensitivity level, bits 3:0.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [14:0] roll_position, [29:15] pitch_position, [31:30] zero
    output logic        m_tuser    // [0] frame_ok
);

    logic [3:0]       level_reg;
    logic             push;
    logic             pop;
    tfps_pkg::frame_t frame_in;
    tfps_pkg::frame_t frame_out;
    tfps_pkg::qstat_t q_stat;

    // The user must write the level register only while the block is idle, so the
    // scaler may sample it at the start of each frame; the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= tfps_pkg::LEVEL_RESET;
        end else if (cfg_valid) begin
            level_reg <= (cfg_data > tfps_pkg::LEVEL_MAX) ? tfps_pkg::LEVEL_MAX : cfg_data;
        end
    end

    tfps_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat_i (q_stat),
        .push_o   (push),
        .frame_o  (frame_in)
    );

    tfps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .data_i  (frame_in),
        .pop_i   (pop),
        .data_o  (frame_out),
        .stat_o  (q_stat)
    );

    tfps_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .level_i  (level_reg),
        .q_stat_i (q_stat),
        .q_data_i (frame_out),
        .pop_o    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The stored level never exceeds the top of the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= tfps_pkg::LEVEL_MAX)
        else $error("sensitivity level above table range");

    // The queue is never full and empty at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("frame queue status inconsistent");

    // A frame is never pushed into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("frame pushed into full queue");

    // Mapped positions never reach the pad bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:30] == 2'b00))
        else $error("result pad bits set");

endmodule

// ===== tb/sv/tilt_frame_parser_scaler_test.sv =====
// ============================================================================
// Tilt frame parser and scaler testbench
// Streams sensor bytes into the parser and checks every result word against
// a predictor of the frame parser and angle scaler. A short table of frames
// covers the extreme angles, the rejected footer and a header byte inside a
// frame. Random frames then follow under several sensitivity levels, with
// bursty input, a stalling receiver and one long output hold-off.
// ============================================================================
module tilt_frame_parser_scaler_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int ITEMS_TOTAL   = 1650;
    // Longer than twice the time for which a good frame keeps the scaler busy.
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 600;
    localparam int LIMIT_CYCLES  = 500000;

    // One result word split into its fields.
    typedef struct packed {
        logic [14:0] roll;
        logic [14:0] pitch;
        logic        ok;
    } tilt_result_t;

    // One row of the directed table: a whole frame plus an optional stray
    // byte in front of it, and the result where it is obvious by eye.
    typedef struct packed {
        logic [3:0]  level;
        logic        has_lead;
        logic [7:0]  lead;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [7:0]  footer;
        logic        typed;
        logic [14:0] roll_exp;
        logic [14:0] pitch_exp;
        logic        ok_exp;
    } frame_row_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_RUNS
    } rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [14:0] roll_position, [29:15] pitch_position, [31:30] zero
    logic        m_tuser;    // [0] frame_ok

    // Predictor state: level, frame slot, collected bytes and held angles.
    int          limit_tbl [11] = '{18000, 16200, 14400, 12600, 10800, 9000,
                                    7400, 5800, 4200, 2600, 1000};
    logic [3:0]  level_q;
    logic [2:0]  pos_q;
    logic [7:0]  frame_buf [8];
    logic [14:0] held_pitch_q;
    logic [14:0] held_roll_q;

    // Results still owed by the block, oldest first.
    tilt_result_t pending_results[$];
    tilt_result_t got;
    tilt_result_t want;

    int mismatches   = 0;
    int useful_items = 0;
    int cycle_count  = 0;
    int burst_left   = 0;

    // Receiver pattern state; hold_req asks for one long hold-off.
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_run  = 0;
    int       hold_left = 0;
    bit       hold_req = 1'b0;

    tilt_frame_parser_scaler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Deadzone, offset by the limit, scale to 15 bits and clamp. Division on
    // signed 64-bit values truncates toward zero.
    function automatic logic [14:0] map_angle(input logic signed [15:0] raw, input int lim);
        longint v;
        longint q;
        longint dz;
        dz = tfps_pkg::DEADZONE;
        v  = raw;
        if (v > -dz && v < dz) begin
            v = 0;
        end
        q = ((v + lim) * longint'(tfps_pkg::OUT_MAX)) / (2 * longint'(lim));
        if (q < 0) begin
            q = 0;
        end
        if (q > longint'(tfps_pkg::OUT_MAX)) begin
            q = longint'(tfps_pkg::OUT_MAX);
        end
        return q[14:0];
    endfunction

    // Feed one accepted word to the predictor. Words outside a frame other
    // than the header are dropped; the eighth byte of a frame closes it and
    // produces one result, updating the held angles only on a good footer.
    task automatic take_byte(input logic [7:0] b, output bit used);
        logic ok;
        used = 1'b0;
        if (pos_q == 3'd0 && b != tfps_pkg::HEADER_BYTE) begin
            return;
        end
        used = 1'b1;
        frame_buf[pos_q] = b;
        if (pos_q != tfps_pkg::LAST_POS) begin
            pos_q = pos_q + 3'd1;
            return;
        end
        pos_q = 3'd0;
        ok = (frame_buf[7] == tfps_pkg::FOOTER_BYTE);
        if (ok) begin
            held_pitch_q = map_angle({frame_buf[3], frame_buf[4]}, limit_tbl[level_q]);
            held_roll_q  = map_angle({frame_buf[5], frame_buf[6]}, limit_tbl[level_q]);
        end
        pending_results.push_back('{roll: held_roll_q, pitch: held_pitch_q, ok: ok});
    endtask

    // Offer one word on the input. The sender runs in bursts of random
    // length; between most bursts tvalid drops for a gap of random length.
    task automatic put_byte(input logic [7:0] b);
        int  gap;
        bit  used;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 19) == 0) begin
                gap = 30;
            end
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        take_byte(b, used);
        if (used) begin
            useful_items++;
        end
    endtask

    // Stop sending and wait for every owed result, then give the scaler
    // time to go quiet before anything about the setup changes.
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the sensitivity level; values above ten read back as ten.
    task automatic write_level(input logic [3:0] lvl);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= lvl;
        do @(posedge aclk); while (!cfg_ready);
        level_q = (lvl > tfps_pkg::LEVEL_MAX) ? tfps_pkg::LEVEL_MAX : lvl;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Angle values that favor the interesting regions: the deadzone, the
    // edges of the input limit, the extremes, in-range values and any 16-bit value.
    function automatic logic [15:0] pick_angle(input int lim);
        int a;
        case ($urandom_range(0, 7))
            0: a = $urandom_range(0, 65535);
            1: a = int'($urandom_range(0, 998)) - 499;
            2: a = (($urandom_range(0, 1) == 1) ? lim : -lim) + int'($urandom_range(0, 40)) - 20;
            3: begin
                case ($urandom_range(0, 5))
                    0: a = -32768;
                    1: a = 32767;
                    2: a = 500;
                    3: a = -500;
                    4: a = 499;
                    default: a = -499;
                endcase
            end
            default: a = int'($urandom_range(0, 2 * lim)) - lim;
        endcase
        return a[15:0];
    endfunction

    // Mostly well-formed frames with random content and an occasional bad
    // footer; now and then a short run of noise instead. Noise may open a
    // frame, so the next frame first fills up whatever frame is open, which
    // gives broken frames with random content.
    task automatic send_frame();
        logic [15:0] p;
        logic [15:0] r;
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
            return;
        end
        while (pos_q != 3'd0) put_byte(8'($urandom_range(0, 255)));
        p = pick_angle(limit_tbl[level_q]);
        r = pick_angle(limit_tbl[level_q]);
        put_byte(tfps_pkg::HEADER_BYTE);
        put_byte(8'($urandom_range(0, 255)));
        put_byte(8'($urandom_range(0, 255)));
        put_byte(p[15:8]);
        put_byte(p[7:0]);
        put_byte(r[15:8]);
        put_byte(r[7:0]);
        if ($urandom_range(0, 9) == 0) begin
            put_byte(8'($urandom_range(0, 255)));
        end else begin
            put_byte(tfps_pkg::FOOTER_BYTE);
        end
    endtask

    // The receiver switches among stall patterns after runs of random length. When
    // the main flow raises hold_req, tready stays low for a long stretch so
    // that the block backs up and stalls its input.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(50, 400);
            end
            rx_left = rx_left - 1;
            case (rx_mode)
                RX_OPEN:        m_tready <= 1'b1;
                RX_COIN:        m_tready <= ($urandom_range(0, 1) == 1);
                RX_ONE_IN_FOUR: m_tready <= (rx_left % 4 == 0);
                default: begin
                    if (rx_run > 0) begin
                        rx_run = rx_run - 1;
                        m_tready <= 1'b0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        rx_run = $urandom_range(5, 30);
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Result checker: each word taken on the output is compared, field by
    // field, with the oldest owed result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = '{roll: m_tdata[14:0], pitch: m_tdata[29:15], ok: m_tuser};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, roll %0d pitch %0d ok %0d",
                         $time, got.roll, got.pitch, got.ok);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.roll !== want.roll) begin
                    $display("%0t: roll_position expected %0d, got %0d",
                             $time, want.roll, got.roll);
                    mismatches++;
                end
                if (got.pitch !== want.pitch) begin
                    $display("%0t: pitch_position expected %0d, got %0d",
                             $time, want.pitch, got.pitch);
                    mismatches++;
                end
                if (got.ok !== want.ok) begin
                    $display("%0t: frame_ok expected %0d, got %0d",
                             $time, want.ok, got.ok);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a run that hangs ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        frame_row_t   frame_rows [3];
        frame_row_t   row;
        logic [3:0]   cfg_shadow;
        logic [3:0]   lvl;
        int           phase;
        int           phase_end;

        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 4'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;

        level_q      = tfps_pkg::LEVEL_RESET;
        pos_q        = 3'd0;
        held_pitch_q = tfps_pkg::MID_VALUE;
        held_roll_q  = tfps_pkg::MID_VALUE;
        foreach (frame_buf[i]) begin
            frame_buf[i] = 8'd0;
        end
        cfg_shadow = tfps_pkg::LEVEL_RESET;

        // Directed frames.
        // Row 0: a stray zero byte is dropped, then a frame whose data bytes
        //   and footer are all header bytes. The header is taken as plain
        //   data inside a frame, the footer is wrong, so the reset values
        //   come back with frame_ok low.
        // Row 1: level fifteen saturates to ten; the most negative pitch
        //   clamps to zero and the most positive roll clamps to full scale.
        // Row 2: level zero; angles just inside the deadzone map to center.
        frame_rows[0] = '{level: tfps_pkg::LEVEL_RESET, has_lead: 1'b1, lead: 8'h00,
                          b1: tfps_pkg::HEADER_BYTE, b2: tfps_pkg::HEADER_BYTE,
                          pitch: 16'hAAAA, roll: 16'hAAAA,
                          footer: tfps_pkg::HEADER_BYTE, typed: 1'b1,
                          roll_exp: tfps_pkg::MID_VALUE,
                          pitch_exp: tfps_pkg::MID_VALUE, ok_exp: 1'b0};
        frame_rows[1] = '{level: 4'd15, has_lead: 1'b1, lead: 8'hFF,
                          b1: 8'h00, b2: 8'hFF, pitch: 16'h8000,
                          roll: 16'h7FFF, footer: tfps_pkg::FOOTER_BYTE, typed: 1'b1,
                          roll_exp: tfps_pkg::OUT_MAX, pitch_exp: 15'd0, ok_exp: 1'b1};
        frame_rows[2] = '{level: 4'd0, has_lead: 1'b0, lead: 8'h00,
                          b1: 8'h55, b2: 8'h80, pitch: 16'd499,
                          roll: -16'sd499, footer: tfps_pkg::FOOTER_BYTE, typed: 1'b1,
                          roll_exp: tfps_pkg::MID_VALUE,
                          pitch_exp: tfps_pkg::MID_VALUE, ok_exp: 1'b1};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (frame_rows[i]) begin
            row = frame_rows[i];
            if (row.level != cfg_shadow) begin
                quiesce();
                write_level(row.level);
                cfg_shadow = row.level;
            end
            if (row.has_lead) begin
                put_byte(row.lead);
            end
            put_byte(tfps_pkg::HEADER_BYTE);
            put_byte(row.b1);
            put_byte(row.b2);
            put_byte(row.pitch[15:8]);
            put_byte(row.pitch[7:0]);
            put_byte(row.roll[15:8]);
            put_byte(row.roll[7:0]);
            put_byte(row.footer);
            // Rows with a hand-written result replace the prediction for
            // the frame that was just closed.
            if (row.typed) begin
                pending_results[$] = '{roll: row.roll_exp, pitch: row.pitch_exp,
                                       ok: row.ok_exp};
            end
        end

        // Random phases. Each starts from a quiet block with a new level;
        // the first few take the extremes and the saturating values. The
        // pause before each write also lets every owed result drain while
        // the sender waits. The second phase runs against a long receiver
        // hold-off so that the frame queue fills and the input stalls.
        phase = 0;
        while (useful_items < ITEMS_TOTAL) begin
            quiesce();
            case (phase)
                0:       lvl = tfps_pkg::LEVEL_MAX;
                1:       lvl = 4'd0;
                2:       lvl = 4'd15;
                3:       lvl = 4'd11;
                default: lvl = 4'($urandom_range(0, 15));
            endcase
            write_level(lvl);
            if (phase == 1) begin
                hold_req = 1'b1;
            end
            phase_end = useful_items + $urandom_range(80, 260);
            while (useful_items < phase_end && useful_items < ITEMS_TOTAL) begin
                send_frame();
            end
            // Close any open frame so the next level applies to whole frames.
            while (pos_q != 3'd0) put_byte(8'($urandom_range(0, 255)));
            phase++;
        end

        quiesce();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
